@@ design/efhs_pkg.sv @@
// ----------------------------------------------------------------------------
// efhs_pkg
// Types, codes and reset values for the fan hysteresis sequencer.
// ----------------------------------------------------------------------------
package efhs_pkg;

  typedef enum logic [1:0] {
    KIND_INIT = 2'd0,
    KIND_TICK = 2'd1,
    KIND_READ = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] read_data;
  } in_item_t;

  typedef struct packed {
    logic       is_access;
    logic       access_write;
    logic       access_port;
    logic [7:0] write_data;
    logic       fan_is_on;
    logic [7:0] temp_reading;
    logic       timed_out;
    logic       last_of_run;
  } out_item_t;

  typedef enum logic [7:0] {
    PH_IDLE  = 8'b0000_0001,
    PH_RCMD  = 8'b0000_0010,
    PH_RREG  = 8'b0000_0100,
    PH_OBF   = 8'b0000_1000,
    PH_RDATA = 8'b0001_0000,
    PH_WCMD  = 8'b0010_0000,
    PH_WREG  = 8'b0100_0000,
    PH_WVAL  = 8'b1000_0000
  } phase_t;

  localparam logic [2:0] REG_ON_THRESHOLD   = 3'd0;
  localparam logic [2:0] REG_OFF_THRESHOLD  = 3'd1;
  localparam logic [2:0] REG_ON_SPEED       = 3'd2;
  localparam logic [2:0] REG_OFF_SPEED      = 3'd3;
  localparam logic [2:0] REG_POLL_LIMIT     = 3'd4;
  localparam logic [2:0] REG_TEMP_REG_INDEX = 3'd5;
  localparam logic [2:0] REG_FAN_REG_INDEX  = 3'd6;

  localparam logic [7:0]  CMD_READ  = 8'h80;
  localparam logic [7:0]  CMD_WRITE = 8'h81;
  localparam int unsigned ST_IBF_BIT = 1;
  localparam int unsigned ST_OBF_BIT = 0;
  localparam logic        PORT_DATA = 1'b0;
  localparam logic        PORT_CMD  = 1'b1;

  localparam logic [7:0]  RST_ON_THRESHOLD   = 8'd59;
  localparam logic [7:0]  RST_OFF_THRESHOLD  = 8'd49;
  localparam logic [7:0]  RST_ON_SPEED       = 8'h01;
  localparam logic [7:0]  RST_OFF_SPEED      = 8'h1f;
  localparam logic [15:0] RST_POLL_LIMIT     = 16'd10000;
  localparam logic [7:0]  RST_TEMP_REG_INDEX = 8'h58;
  localparam logic [7:0]  RST_FAN_REG_INDEX  = 8'h55;

  function automatic out_item_t poll_req();
    out_item_t r;
    r = '0;
    r.is_access   = 1'b1;
    r.access_port = PORT_CMD;
    return r;
  endfunction

  function automatic out_item_t data_read_req();
    out_item_t r;
    r = '0;
    r.is_access   = 1'b1;
    r.access_port = PORT_DATA;
    return r;
  endfunction

  function automatic out_item_t write_req(input logic port, input logic [7:0] data);
    out_item_t r;
    r = '0;
    r.is_access    = 1'b1;
    r.access_write = 1'b1;
    r.access_port  = port;
    r.write_data   = data;
    return r;
  endfunction

endpackage

@@ design/ec_fan_hysteresis_sequencer.sv @@
// ----------------------------------------------------------------------------
// ec_fan_hysteresis_sequencer
// Host-side byte protocol sequencer that reads a temperature from an
// embedded controller and switches a fan with a two-state hysteresis rule.
// ----------------------------------------------------------------------------
// Usage:
//   in_item requests: init (force fan off), control tick, or the byte that
//   the host returned for the last port read. Each accepted request yields
//   zero, one or two requests on out_item: port reads, port writes and one
//   end-of-cycle report per control cycle; last_of_run marks the final one.
//   Results are registered and appear the cycle after acceptance, one per
//   cycle while taken. One request per cycle is accepted when each yields at
//   most one result and each result is taken; a request yielding two results
//   holds off the next while the two-entry buffer drains. in_ready stays high
//   while the buffer holds at most one result that is taken in the same
//   cycle, so input and output overlap. When the receiver stalls, results
//   stay in the buffer and in_ready drops once it is occupied. Reset (rst,
//   synchronous) sets the phase idle, fan off, temperature and error flag
//   zero, and all configuration registers to their defaults. Configuration
//   is written through cfg_we/cfg_index/cfg_data; the user must write only
//   while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module ec_fan_hysteresis_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  efhs_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output efhs_pkg::out_item_t out_item
);
  import efhs_pkg::*;

  logic [7:0]  on_threshold, off_threshold, on_speed, off_speed;
  logic [15:0] poll_limit;
  logic [7:0]  temp_reg_index, fan_reg_index;

  phase_t      phase, phase_next;
  logic [15:0] poll_count, poll_count_next, poll_inc;
  logic        fan_on, fan_on_next;
  logic [7:0]  temperature, temperature_next;
  logic [7:0]  pending_write, pending_write_next;
  logic        error_seen, error_seen_next;

  logic [1:0]  count;
  out_item_t   slot0, slot1;
  out_item_t   res0, res1, acc_res, fol_res;
  logic [1:0]  n_res;
  logic        in_fire, pop, st_ready, timeout;
  logic [7:0]  d;

  assign in_ready  = (count == 2'd0) || ((count == 2'd1) && out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && out_ready;
  assign out_item  = slot0;
  assign d         = in_item.read_data;

  always_comb begin
    phase_next         = phase;
    poll_count_next    = poll_count;
    fan_on_next        = fan_on;
    temperature_next   = temperature;
    pending_write_next = pending_write;
    error_seen_next    = error_seen;
    res0     = '0;
    res1     = '0;
    acc_res  = '0;
    fol_res  = '0;
    n_res    = 2'd0;
    timeout  = 1'b0;
    poll_inc = poll_count + 16'd1;
    st_ready = (phase == PH_OBF) ? d[ST_OBF_BIT] : !d[ST_IBF_BIT];

    unique case (phase)
      PH_RCMD: acc_res = write_req(PORT_CMD, CMD_READ);
      PH_RREG: acc_res = write_req(PORT_DATA, temp_reg_index);
      PH_WCMD: acc_res = write_req(PORT_CMD, CMD_WRITE);
      PH_WREG: acc_res = write_req(PORT_DATA, fan_reg_index);
      default: acc_res = write_req(PORT_DATA, pending_write);
    endcase

    if (in_fire) begin
      unique case (in_item.kind)
        KIND_INIT: begin
          error_seen_next    = 1'b0;
          fan_on_next        = 1'b0;
          pending_write_next = off_speed;
          poll_count_next    = '0;
          phase_next         = PH_WCMD;
          res0               = poll_req();
          n_res              = 2'd1;
        end
        KIND_TICK: begin
          if (phase == PH_IDLE) begin
            error_seen_next = 1'b0;
            poll_count_next = '0;
            phase_next      = PH_RCMD;
            res0            = poll_req();
            n_res           = 2'd1;
          end
        end
        KIND_READ: begin
          if (phase == PH_RDATA) begin
            temperature_next = d;
            n_res            = 2'd1;
            if (!fan_on && (d >= on_threshold)) begin
              fan_on_next        = 1'b1;
              pending_write_next = on_speed;
              poll_count_next    = '0;
              phase_next         = PH_WCMD;
              res0               = poll_req();
            end else if (fan_on && (d <= off_threshold)) begin
              fan_on_next        = 1'b0;
              pending_write_next = off_speed;
              poll_count_next    = '0;
              phase_next         = PH_WCMD;
              res0               = poll_req();
            end else begin
              phase_next = PH_IDLE;
            end
          end else if (phase != PH_IDLE) begin
            if (!st_ready) begin
              if (poll_inc < poll_limit) begin
                poll_count_next = poll_inc;
                res0            = poll_req();
                n_res           = 2'd1;
              end else begin
                error_seen_next = 1'b1;
                timeout         = 1'b1;
              end
            end
            if (st_ready || timeout) begin
              poll_count_next = '0;
              if (phase == PH_OBF) begin
                n_res = 2'd1;
                if (timeout) begin
                  phase_next = PH_IDLE;
                end else begin
                  phase_next = PH_RDATA;
                  res0       = data_read_req();
                end
              end else begin
                unique case (phase)
                  PH_RCMD: phase_next = PH_RREG;
                  PH_RREG: phase_next = PH_OBF;
                  PH_WCMD: phase_next = PH_WREG;
                  PH_WREG: phase_next = PH_WVAL;
                  default: phase_next = PH_IDLE;
                endcase
                fol_res = (phase == PH_WVAL) ? out_item_t'('0) : poll_req();
                if (timeout) begin
                  res0  = fol_res;
                  n_res = 2'd1;
                end else begin
                  res0  = acc_res;
                  res1  = fol_res;
                  n_res = 2'd2;
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end

    res0.fan_is_on    = fan_on_next;
    res0.temp_reading = temperature_next;
    res0.timed_out    = error_seen_next;
    res0.last_of_run  = (n_res == 2'd1);
    res1.fan_is_on    = fan_on_next;
    res1.temp_reading = temperature_next;
    res1.timed_out    = error_seen_next;
    res1.last_of_run  = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      on_threshold   <= RST_ON_THRESHOLD;
      off_threshold  <= RST_OFF_THRESHOLD;
      on_speed       <= RST_ON_SPEED;
      off_speed      <= RST_OFF_SPEED;
      poll_limit     <= RST_POLL_LIMIT;
      temp_reg_index <= RST_TEMP_REG_INDEX;
      fan_reg_index  <= RST_FAN_REG_INDEX;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ON_THRESHOLD:   on_threshold   <= cfg_data[7:0];
        REG_OFF_THRESHOLD:  off_threshold  <= cfg_data[7:0];
        REG_ON_SPEED:       on_speed       <= cfg_data[7:0];
        REG_OFF_SPEED:      off_speed      <= cfg_data[7:0];
        REG_POLL_LIMIT:     poll_limit     <= cfg_data;
        REG_TEMP_REG_INDEX: temp_reg_index <= cfg_data[7:0];
        REG_FAN_REG_INDEX:  fan_reg_index  <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      poll_count    <= '0;
      fan_on        <= 1'b0;
      temperature   <= '0;
      pending_write <= '0;
      error_seen    <= 1'b0;
      count         <= 2'd0;
    end else begin
      phase         <= phase_next;
      poll_count    <= poll_count_next;
      fan_on        <= fan_on_next;
      temperature   <= temperature_next;
      pending_write <= pending_write_next;
      error_seen    <= error_seen_next;
      if (in_fire) begin
        count <= n_res;
      end else if (pop) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      slot0 <= res0;
      slot1 <= res1;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result buffer count out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> ((count == 2'd0) || out_ready))
    else $error("request accepted over an untaken result");

  a_rdata_clear: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_RDATA) |-> (poll_count == '0))
    else $error("poll count not cleared in data read phase");

  a_empty_after_none: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (n_res == 2'd0)) |=> !out_valid)
    else $error("result shown for a request that causes none");

endmodule
